[rtl/core/wstq_pkg.sv]
// ============================================================================
// wstq_pkg
// Shared widths and command codes for the work-stealing task queue block.
// ============================================================================
package wstq_pkg;

    localparam int WORKER_W = 2;
    localparam int TASK_W   = 16;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_GET  = 1'b1;

endpackage

[rtl/core/wstq_ram.sv]
// ============================================================================
// wstq_ram
// Generic single-port synchronous RAM with registered read data.
// ============================================================================
module wstq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/work_stealing_task_queues_top.sv]
// ============================================================================
// work_stealing_task_queues_top
// Per-worker ring deques of task ids with owner pop and round-robin stealing.
//
// Usage: drive command, worker and task_id with start high while busy is low;
// the item is taken at that edge and busy rises until the result goes out.
// Each item gives exactly one result, shown for one cycle with done high:
// push_ok, task_valid, task_out, was_stolen and source_queue. The receiver
// cannot stall; the result is simply presented for that one cycle.
// Each item is taken into the own-deque state, where its worker's pointers
// are read. A push, a bad worker index or an empty get with no victim ends
// there; a get served from the own deque goes on to the data state, and a
// get that probes a victim goes to the victim state, then to the data state
// if the victim is not empty. Only one item is in flight at a time; busy
// falls in the cycle the result is shown, so the next item can be taken at
// the edge that takes the result. The path is set by the single-port task
// RAM (one registered read per item) and the pointer table, which is read
// at one deque per cycle: own deque first, then the victim.
// Reset clears all bottom, top and victim pointers; the task RAM is not
// cleared since only entries between top and bottom are ever returned.
// ============================================================================
module work_stealing_task_queues_top #(
    parameter int NUM_QUEUES = 4,
    parameter int LOG_DEPTH  = 4,
    parameter int ID_BITS    = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          command,
    input  logic [wstq_pkg::WORKER_W-1:0] worker,
    input  logic [wstq_pkg::TASK_W-1:0]   task_id,
    output logic                          done,
    output logic                          push_ok,
    output logic                          task_valid,
    output logic [wstq_pkg::TASK_W-1:0]   task_out,
    output logic                          was_stolen,
    output logic [wstq_pkg::WORKER_W-1:0] source_queue
);

    import wstq_pkg::*;

    localparam int QW     = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int PW     = LOG_DEPTH + 1;
    localparam int DEPTH  = 1 << LOG_DEPTH;
    localparam int RAM_AW = QW + LOG_DEPTH;
    localparam int RAM_D  = 1 << RAM_AW;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_OWN,
        ST_VICT,
        ST_DATA
    } state_t;

    typedef struct packed {
        logic [PW-1:0] bot;
        logic [PW-1:0] top;
        logic [QW-1:0] vic;
    } ptr_rec_t;

    state_t   state_reg, state_next;
    ptr_rec_t ptr_reg [NUM_QUEUES];

    logic                cmd_reg;
    logic [WORKER_W-1:0] wrk_reg;
    logic [TASK_W-1:0]   id_reg;
    logic [QW-1:0]       qsel_reg, qsel_next;
    logic                steal_reg, steal_next;

    logic                done_reg, done_next;
    logic                ok_reg, ok_next;
    logic                valid_reg, valid_next;
    logic [TASK_W-1:0]   task_reg, task_next;
    logic                stolen_reg, stolen_next;
    logic [WORKER_W-1:0] src_reg, src_next;

    logic          accept;
    logic          in_range;
    logic [QW-1:0] wq;
    logic [QW-1:0] ptr_addr;
    ptr_rec_t      rec;
    ptr_rec_t      ptr_wd;
    logic          ptr_we;
    logic [PW-1:0] fill;
    logic [PW-1:0] bot_dec;
    logic [QW-1:0] vic_sel;
    logic [QW-1:0] vic_adv;

    logic                 ram_we;
    logic [QW-1:0]        ram_q;
    logic [LOG_DEPTH-1:0] ram_slot;
    logic [ID_BITS-1:0]   ram_wdata;
    logic [ID_BITS-1:0]   ram_rdata;
    logic [63:0]          id_wide;
    logic [63:0]          rd_wide;

    function automatic logic [QW-1:0] q_wrap_inc(input logic [QW-1:0] q);
        logic [QW-1:0] r;
        if (q == QW'(NUM_QUEUES - 1))
        begin
            r = '0;
        end
        else
        begin
            r = q + QW'(1);
        end
        return r;
    endfunction

    assign accept   = start && !busy;
    assign busy     = (state_reg != ST_IDLE);
    assign in_range = ({30'd0, wrk_reg} < 32'(NUM_QUEUES));
    assign wq       = in_range ? QW'(wrk_reg) : '0;
    assign ptr_addr = (state_reg == ST_VICT) ? qsel_reg : wq;
    assign rec      = ptr_reg[ptr_addr];
    assign fill     = rec.bot - rec.top;
    assign bot_dec  = rec.bot - PW'(1);
    assign vic_sel  = (rec.vic == wq) ? q_wrap_inc(rec.vic) : rec.vic;
    assign vic_adv  = q_wrap_inc(vic_sel);

    assign id_wide   = 64'(id_reg);
    assign ram_wdata = id_wide[ID_BITS-1:0];
    assign rd_wide   = 64'(ram_rdata);

    wstq_ram #(
        .WIDTH (ID_BITS),
        .DEPTH (RAM_D)
    ) u_task_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  ({ram_q, ram_slot}),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next  = state_reg;
        qsel_next   = qsel_reg;
        steal_next  = steal_reg;
        done_next   = 1'b0;
        ok_next     = 1'b0;
        valid_next  = 1'b0;
        task_next   = '0;
        stolen_next = 1'b0;
        src_next    = '0;
        ptr_we      = 1'b0;
        ptr_wd      = rec;
        ram_we      = 1'b0;
        ram_q       = wq;
        ram_slot    = rec.bot[LOG_DEPTH-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_OWN;
                end
            end
            ST_OWN:
            begin
                if (!in_range)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (cmd_reg == CMD_PUSH)
                begin
                    if (fill < PW'(DEPTH - 1))
                    begin
                        ram_we     = 1'b1;
                        ptr_we     = 1'b1;
                        ptr_wd.bot = rec.bot + PW'(1);
                        ok_next    = 1'b1;
                    end
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (fill != '0)
                begin
                    ram_slot = bot_dec[LOG_DEPTH-1:0];
                    ptr_we   = 1'b1;
                    if (fill == PW'(1))
                    begin
                        ptr_wd.top = rec.top + PW'(1);
                    end
                    else
                    begin
                        ptr_wd.bot = bot_dec;
                    end
                    qsel_next  = wq;
                    steal_next = 1'b0;
                    state_next = ST_DATA;
                end
                else if (vic_sel != wq)
                begin
                    ptr_we     = 1'b1;
                    ptr_wd.vic = vic_adv;
                    qsel_next  = vic_sel;
                    state_next = ST_VICT;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_VICT:
            begin
                if (fill != '0)
                begin
                    ram_q      = qsel_reg;
                    ram_slot   = rec.top[LOG_DEPTH-1:0];
                    ptr_we     = 1'b1;
                    ptr_wd.top = rec.top + PW'(1);
                    steal_next = 1'b1;
                    state_next = ST_DATA;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_DATA:
            begin
                done_next   = 1'b1;
                valid_next  = 1'b1;
                task_next   = rd_wide[TASK_W-1:0];
                stolen_next = steal_reg;
                src_next    = WORKER_W'(qsel_reg);
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            done_reg   <= 1'b0;
            ok_reg     <= 1'b0;
            valid_reg  <= 1'b0;
            stolen_reg <= 1'b0;
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                ptr_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            ok_reg     <= ok_next;
            valid_reg  <= valid_next;
            stolen_reg <= stolen_next;
            if (ptr_we)
            begin
                ptr_reg[ptr_addr] <= ptr_wd;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= command;
            wrk_reg <= worker;
            id_reg  <= task_id;
        end
        qsel_reg  <= qsel_next;
        steal_reg <= steal_next;
        task_reg  <= task_next;
        src_reg   <= src_next;
    end

    assign done         = done_reg;
    assign push_ok      = ok_reg;
    assign task_valid   = valid_reg;
    assign task_out     = task_reg;
    assign was_stolen   = stolen_reg;
    assign source_queue = src_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == ST_IDLE))
        else $error("result strobe while a request is still in flight");

    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        !(ok_reg && valid_reg))
        else $error("push accepted and task returned for the same item");

    a_steal_other: assert property (@(posedge clk) disable iff (!rst_n)
        stolen_reg |-> (valid_reg && (qsel_reg != QW'(wrk_reg))))
        else $error("steal reported from the requesting worker's own deque");

    a_accept_own: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_OWN))
        else $error("accepted item did not start with its own deque lookup");

endmodule

[tb/sv/work_stealing_task_queues_top_test.sv]
// ============================================================================
// work_stealing_task_queues_top_test
// Self-checking bench for the work-stealing task queues. Directed items cover
// owner pop, full deque refusal, empty get and steal; mixed random traffic
// then runs with bursts that fill and drain single deques. A behavioral
// copy of the deques predicts every result, which is compared field by
// field when the done strobe shows it.
// ============================================================================
module work_stealing_task_queues_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    import wstq_pkg::*;

    localparam int NQ        = 4;
    localparam int LOG_DEPTH = 4;
    localparam int DEPTH     = 1 << LOG_DEPTH;
    localparam int PTR_W     = LOG_DEPTH + 1;
    localparam int STALL_MAX = 1000;

    typedef struct packed {
        logic              push_ok;
        logic              task_valid;
        logic [TASK_W-1:0] task_out;
        logic              was_stolen;
        logic [WORKER_W-1:0] source_queue;
    } result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                command = CMD_PUSH;
    logic [WORKER_W-1:0] worker = '0;
    logic [TASK_W-1:0]   task_id = '0;
    logic                busy;
    logic                done;
    logic                push_ok;
    logic                task_valid;
    logic [TASK_W-1:0]   task_out;
    logic                was_stolen;
    logic [WORKER_W-1:0] source_queue;

    logic [PTR_W-1:0]    bottom_ptr [NQ] = '{default: '0};
    logic [PTR_W-1:0]    top_ptr [NQ] = '{default: '0};
    logic [TASK_W-1:0]   task_mem [NQ][DEPTH];
    logic [WORKER_W-1:0] next_victim [NQ] = '{default: '0};

    result_t pending_results [$];
    int      mismatches = 0;
    int      quiet_cycles = 0;

    work_stealing_task_queues_top #(
        .NUM_QUEUES (NQ),
        .LOG_DEPTH  (LOG_DEPTH),
        .ID_BITS    (TASK_W)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .worker       (worker),
        .task_id      (task_id),
        .done         (done),
        .push_ok      (push_ok),
        .task_valid   (task_valid),
        .task_out     (task_out),
        .was_stolen   (was_stolen),
        .source_queue (source_queue)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic result_t serve_request(input logic cmd, input logic [WORKER_W-1:0] w,
                                              input logic [TASK_W-1:0] id);
        result_t          r;
        logic [PTR_W-1:0] fill;
        logic [PTR_W-1:0] b;
        int               v;
        r = '0;
        fill = bottom_ptr[w] - top_ptr[w];
        if (cmd == CMD_PUSH)
        begin
            if (fill < DEPTH - 1)
            begin
                task_mem[w][bottom_ptr[w][LOG_DEPTH-1:0]] = id;
                bottom_ptr[w] = bottom_ptr[w] + 1'b1;
                r.push_ok = 1'b1;
            end
        end
        else if (fill != 0)
        begin
            b = bottom_ptr[w] - 1'b1;
            r.task_out = task_mem[w][b[LOG_DEPTH-1:0]];
            if (fill == 1)
                top_ptr[w] = top_ptr[w] + 1'b1;
            else
                bottom_ptr[w] = b;
            r.task_valid = 1'b1;
            r.source_queue = w;
        end
        else
        begin
            v = next_victim[w] % NQ;
            if (v == w)
                v = (v + 1) % NQ;
            if (v != w)
            begin
                next_victim[w] = WORKER_W'((v + 1) % NQ);
                if (bottom_ptr[v] != top_ptr[v])
                begin
                    r.task_out = task_mem[v][top_ptr[v][LOG_DEPTH-1:0]];
                    top_ptr[v] = top_ptr[v] + 1'b1;
                    r.task_valid = 1'b1;
                    r.was_stolen = 1'b1;
                    r.source_queue = WORKER_W'(v);
                end
            end
        end
        return r;
    endfunction

    task automatic send_item(input logic cmd, input logic [WORKER_W-1:0] w,
                             input logic [TASK_W-1:0] id, input int idle_pct);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
        start   <= 1'b1;
        command <= cmd;
        worker  <= w;
        task_id <= id;
        do @(posedge clk); while (busy);
        pending_results.push_back(serve_request(cmd, w, id));
    endtask

    task automatic wait_all_results();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no item outstanding");
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("push_ok", want.push_ok, push_ok);
                check_field("task_valid", want.task_valid, task_valid);
                check_field("task_out", want.task_out, task_out);
                check_field("was_stolen", want.was_stolen, was_stolen);
                check_field("source_queue", want.source_queue, source_queue);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_MAX)
            begin
                $error("no item or result for %0d cycles", STALL_MAX);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic test_empty_get();
        send_item(CMD_GET, 2'd0, 16'hFFFF, 0);
        send_item(CMD_GET, 2'd3, 16'h0000, 0);
    endtask

    task automatic test_owner_pop();
        send_item(CMD_PUSH, 2'd0, 16'hFFFF, 0);
        send_item(CMD_PUSH, 2'd0, 16'h0000, 0);
        send_item(CMD_GET, 2'd0, 16'h0000, 0);
        send_item(CMD_GET, 2'd0, 16'hFFFF, 0);
    endtask

    task automatic test_full_deque();
        repeat (DEPTH)
            send_item(CMD_PUSH, 2'd1, TASK_W'($urandom()), 0);
    endtask

    task automatic test_steal();
        send_item(CMD_GET, 2'd2, 16'h5A5A, 0);
        send_item(CMD_GET, 2'd2, 16'hA5A5, 0);
    endtask

    task automatic test_random_traffic(input int n_items, input int idle_pct);
        int                  sent;
        int                  pick;
        int                  burst;
        logic [WORKER_W-1:0] w;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(99);
            w = WORKER_W'($urandom_range(NQ - 1));
            if (pick < 12)
            begin
                burst = $urandom_range(18, 8);
                repeat (burst)
                    send_item(CMD_PUSH, w, TASK_W'($urandom()), idle_pct);
                sent += burst;
            end
            else if (pick < 24)
            begin
                burst = $urandom_range(12, 4);
                repeat (burst)
                    send_item(CMD_GET, w, TASK_W'($urandom()), idle_pct);
                sent += burst;
            end
            else
            begin
                send_item(1'($urandom_range(1)), w, TASK_W'($urandom()), idle_pct);
                sent++;
            end
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_get();
        test_owner_pop();
        test_full_deque();
        test_steal();
        wait_all_results();
        test_random_traffic(650, 0);
        wait_all_results();
        test_random_traffic(650, 50);
        wait_all_results();
        test_random_traffic(650, 12);
        wait_all_results();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
